// ===== sv/bidq_pkg.sv =====
// Shared definitions for the bounded integer deque with search.
// Holds default sizes, fixed port widths and the command codes.
// No dependencies; compile this file first.
package bidq_pkg;

  // Default sizing for the top level.
  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed widths of the item fields.
  localparam int CMD_W       = 3;
  localparam int IN_VALUE_W  = 32;
  localparam int OUT_VALUE_W = 32;
  localparam int COUNT_W     = 7;

  // Command codes carried by the input item.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_CONTAINS   = 3'd4,
    CMD_REMOVE     = 3'd5
  } cmd_t;

endpackage

// ===== sv/bounded_int_deque_with_search.sv =====
// Bounded deque of signed integers with search and removal by value.
// Depends on bidq_pkg and bidq_ram.
//
//   channel | direction | handshake           | fields
//   --------+-----------+---------------------+--------------------------------------
//   in_     | input     | in_valid / in_stall | in_cmd, in_value
//   out_    | output    | out_valid/out_stall | out_ok, out_value_out, out_count,
//           |           |                     | out_is_empty
//
// Pops pass through ST_POP for the registered RAM read; pushes go straight to ST_RESULT.
// Contains and remove walk the ring one entry per cycle through the single RAM.
// One item is in flight at a time; in_stall is high whenever the block is busy.
// A finished result waits in the output register while a new item is accepted.
// Reset (synchronous, rst_n low) empties the deque; the RAM contents are not cleared.
module bounded_int_deque_with_search #(
  parameter int CAPACITY   = bidq_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = bidq_pkg::VALUE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [bidq_pkg::CMD_W-1:0]              in_cmd,
  input  logic signed [bidq_pkg::IN_VALUE_W-1:0]  in_value,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    out_ok,
  output logic signed [bidq_pkg::OUT_VALUE_W-1:0] out_value_out,
  output logic [bidq_pkg::COUNT_W-1:0]            out_count,
  output logic                                    out_is_empty
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_SEARCH,
    ST_SHIFT,
    ST_RESULT
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  rm_r, rm_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [CW-1:0]         scan_r, scan_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic                  res_ok_r, res_ok_nxt;
  logic [bidq_pkg::OUT_VALUE_W-1:0] res_val_r, res_val_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic [bidq_pkg::OUT_VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [bidq_pkg::COUNT_W-1:0]     out_count_r, out_count_nxt;
  logic                  out_empty_r, out_empty_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  logic [VALUE_BITS-1:0] in_val_cut;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [AW-1:0]         head_dec;
  logic [AW-1:0]         head_inc;
  logic [CW-1:0]         count_m1;
  logic                  match;
  logic [CW:0]           pos_p1;
  logic [CW:0]           pos_p2;
  logic                  out_free;

  // Ring position of an offset from a base, wrapped at the capacity.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(CAPACITY)) begin
      sum = sum - (AW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  // Entry storage.
  bidq_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake and shared decode.
  assign in_stall   = (state_r != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign in_val_cut = VALUE_BITS'(in_value);
  assign full       = (count_r == CW'(CAPACITY));
  assign empty      = (count_r == '0);
  assign head_dec   = (head_r == '0) ? AW'(CAPACITY - 1) : head_r - AW'(1);
  assign head_inc   = slot_of(head_r, AW'(1));
  assign count_m1   = count_r - CW'(1);
  assign match      = cmp_vld_r && (ram_rdata == val_r);
  assign pos_p1     = (CW+1)'(pos_r) + (CW+1)'(1);
  assign pos_p2     = (CW+1)'(pos_r) + (CW+1)'(2);
  assign out_free   = !out_valid_r || !out_stall;

  // Command sequencer: next state, RAM accesses and result formation.
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    rm_nxt        = rm_r;
    val_nxt       = val_r;
    scan_nxt      = scan_r;
    cmp_vld_nxt   = cmp_vld_r;
    pos_nxt       = pos_r;
    res_ok_nxt    = res_ok_r;
    res_val_nxt   = res_val_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_value_nxt = out_value_r;
    out_count_nxt = out_count_r;
    out_empty_nxt = out_empty_r;
    ram_we        = 1'b0;
    ram_waddr     = head_r;
    ram_wdata     = in_val_cut;
    ram_re        = 1'b0;
    ram_raddr     = head_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_ok_nxt  = 1'b0;
          res_val_nxt = '0;
          val_nxt     = in_val_cut;
          state_nxt   = ST_RESULT;
          case (bidq_pkg::cmd_t'(in_cmd))
            bidq_pkg::CMD_PUSH_FRONT: begin
              if (!full) begin
                ram_we     = 1'b1;
                ram_waddr  = head_dec;
                head_nxt   = head_dec;
                count_nxt  = count_r + CW'(1);
                res_ok_nxt = 1'b1;
              end
            end
            bidq_pkg::CMD_PUSH_BACK: begin
              if (!full) begin
                ram_we     = 1'b1;
                ram_waddr  = slot_of(head_r, count_r[AW-1:0]);
                count_nxt  = count_r + CW'(1);
                res_ok_nxt = 1'b1;
              end
            end
            bidq_pkg::CMD_POP_FRONT: begin
              if (!empty) begin
                ram_re     = 1'b1;
                ram_raddr  = head_r;
                head_nxt   = head_inc;
                count_nxt  = count_m1;
                res_ok_nxt = 1'b1;
                state_nxt  = ST_POP;
              end
            end
            bidq_pkg::CMD_POP_BACK: begin
              if (!empty) begin
                ram_re     = 1'b1;
                ram_raddr  = slot_of(head_r, count_m1[AW-1:0]);
                count_nxt  = count_m1;
                res_ok_nxt = 1'b1;
                state_nxt  = ST_POP;
              end
            end
            bidq_pkg::CMD_CONTAINS, bidq_pkg::CMD_REMOVE: begin
              rm_nxt      = (bidq_pkg::cmd_t'(in_cmd) == bidq_pkg::CMD_REMOVE);
              scan_nxt    = '0;
              cmp_vld_nxt = 1'b0;
              state_nxt   = ST_SEARCH;
            end
            default: begin
              state_nxt = ST_RESULT;
            end
          endcase
        end
      end

      // Popped entry arrives from the RAM.
      ST_POP: begin
        res_val_nxt = bidq_pkg::OUT_VALUE_W'(ram_rdata);
        state_nxt   = ST_RESULT;
      end

      // Walk from the front: issue one read and check the previous one per cycle.
      ST_SEARCH: begin
        if (match) begin
          res_ok_nxt  = 1'b1;
          cmp_vld_nxt = 1'b0;
          if (!rm_r) begin
            state_nxt = ST_RESULT;
          end else if (pos_p1 < (CW+1)'(count_r)) begin
            ram_re    = 1'b1;
            ram_raddr = slot_of(head_r, pos_p1[AW-1:0]);
            state_nxt = ST_SHIFT;
          end else begin
            count_nxt = count_m1;
            state_nxt = ST_RESULT;
          end
        end else if (scan_r == count_r) begin
          cmp_vld_nxt = 1'b0;
          state_nxt   = ST_RESULT;
        end else begin
          ram_re      = 1'b1;
          ram_raddr   = slot_of(head_r, scan_r[AW-1:0]);
          pos_nxt     = scan_r[AW-1:0];
          cmp_vld_nxt = 1'b1;
          scan_nxt    = scan_r + CW'(1);
        end
      end

      // Close the gap: write the entry read last cycle one place toward the front.
      ST_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = slot_of(head_r, pos_r);
        ram_wdata = ram_rdata;
        if (pos_p2 < (CW+1)'(count_r)) begin
          ram_re    = 1'b1;
          ram_raddr = slot_of(head_r, pos_p2[AW-1:0]);
          pos_nxt   = pos_p1[AW-1:0];
        end else begin
          count_nxt = count_m1;
          state_nxt = ST_RESULT;
        end
      end

      // Hand the result to the output register once it is free.
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_value_nxt = res_val_r;
          out_count_nxt = bidq_pkg::COUNT_W'(count_r);
          out_empty_nxt = empty;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rm_r        <= rm_nxt;
    val_r       <= val_nxt;
    scan_r      <= scan_nxt;
    pos_r       <= pos_nxt;
    res_ok_r    <= res_ok_nxt;
    res_val_r   <= res_val_nxt;
    out_ok_r    <= out_ok_nxt;
    out_value_r <= out_value_nxt;
    out_count_r <= out_count_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_value_out = out_value_r;
  assign out_count     = out_count_r;
  assign out_is_empty  = out_empty_r;

  // The entry count never exceeds the capacity.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // The head index always names a real slot of the ring.
  assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, head_r} < (AW+1)'(CAPACITY))
    else $error("head index out of range");

  // The RAM is written only by an accepted push or by the gap-closing walk.
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (accept || (state_r == ST_SHIFT)))
    else $error("unexpected RAM write");

  // A result ready with a free output register is presented next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RESULT) && out_free) |=> out_valid)
    else $error("result not presented");

endmodule

// ===== sv/bidq_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Read data is registered and appears in the cycle after a read enable. No dependencies.
module bidq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
